>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is held.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent check that also runs through reset.
`define CHK_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/tapp_pkg.sv
`timescale 1ns / 1ps

package tapp_pkg;

    // Rotation cells; the arctangent table limits how many can be used.
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int NUM_CELLS     = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int STAGE_W       = $clog2(TABLE_LEN);
    localparam int FRONT_STAGES  = 9;

    // Port widths.
    localparam int COL_W     = 12;
    localparam int ROW_W     = 11;
    localparam int FRAME_W   = 10;
    localparam int OUT_W     = 24;
    localparam int CFG_W     = 32;
    localparam int DPF_W     = 24;
    localparam int CFG_IDX_W = 3;

    // Internal widths.
    localparam int KX_W      = 45;   // slope times pixel coordinate
    localparam int D_W       = 46;   // signed distances, Q.28
    localparam int MAG_SHIFT = 14;   // Q.28 to Q.14
    localparam int MAG_W     = D_W - MAG_SHIFT;
    localparam int NORM_SHIFT = 35;  // Q.14 times Q1.31 down to Q.10
    localparam int R_W       = 2 * MAG_W - NORM_SHIFT;
    localparam int GAIN_W    = 31;
    localparam int GAIN_SHIFT = 23;
    localparam int CX_W      = R_W + GAIN_W - GAIN_SHIFT;
    localparam int ROT_W     = 40;
    localparam int ANG_W     = 32;
    localparam int FD_W      = FRAME_W + DPF_W;
    localparam int DEG_W     = FD_W + 1;
    localparam int CHUNK_W   = 12;   // 2^12 is one more than a multiple of 45
    localparam int S1_W      = CHUNK_W + 2;
    localparam int S2_W      = CHUNK_W + 1;
    localparam int RECIP_W   = 17;
    localparam int RECIP_SHIFT = 22;
    localparam int QPROD_W   = S2_W + RECIP_W;
    localparam int Q_W       = 7;
    localparam int B_W       = 6;
    localparam int FRAC_W    = 13;
    localparam int A_W       = ANG_W - FRAC_W;
    localparam int SAT_W     = ROT_W + 1;
    localparam int RND_SHIFT = 8;

    // Arithmetic constants.
    localparam logic [GAIN_W-1:0]  INV_GAIN_Q31 = 31'd1304065748;
    localparam logic [DEG_W-1:0]   DEG180_Q16   = 35'd11796480;
    localparam int                 MOD_DIV      = 45;   // 360 deg over 2^3
    localparam logic [RECIP_W-1:0] RECIP45      = 17'd93207;
    localparam logic [A_W-1:0]     INV45_MOD    = 19'd151461;  // 45 * x = 1 mod 2^19
    localparam logic signed [SAT_W-1:0] RND_HALF = SAT_W'(2 ** (RND_SHIFT - 1));
    localparam logic signed [SAT_W-1:0] SAT_HI   = SAT_W'(2 ** (OUT_W - 1) - 1);
    localparam logic signed [SAT_W-1:0] SAT_LO   = SAT_W'(-(2 ** (OUT_W - 1)));

    typedef logic signed [ANG_W-1:0] t_angle;

    // Arctangent of 2^-i as a binary angle, 2^32 for a full turn.
    localparam t_angle ATAN_TBL [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Fractional part of a binary angle for each remainder modulo 45.
    typedef logic [MOD_DIV-1:0][FRAC_W-1:0] t_frac_tbl;

    function automatic t_frac_tbl build_frac_tbl();
        t_frac_tbl tbl;
        for (int i = 0; i < MOD_DIV; i++) begin
            tbl[i] = FRAC_W'((i * (2 ** FRAC_W)) / MOD_DIV);
        end
        return tbl;
    endfunction

    localparam t_frac_tbl FRAC_TBL = build_frac_tbl();

    // Register map.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AXIS_SLOPE    = 3'd0,
        CFG_AXIS_OFFSET   = 3'd1,
        CFG_BASE_OFFSET   = 3'd2,
        CFG_INVERSE_NORM  = 3'd3,
        CFG_DEG_PER_FRAME = 3'd4
    } t_cfg_index;

    localparam logic signed [CFG_W-1:0] RST_AXIS_SLOPE   = 32'sd0;
    localparam logic signed [CFG_W-1:0] RST_AXIS_OFFSET  = 32'sd67108864;
    localparam logic signed [CFG_W-1:0] RST_BASE_OFFSET  = -32'sd154009600;
    localparam logic [CFG_W-1:0]        RST_INVERSE_NORM = 32'h8000_0000;
    localparam logic [DPF_W-1:0]        RST_DEG_PER_FRAME = 24'd65536;

    typedef struct packed {
        logic signed [CFG_W-1:0] axis_slope;
        logic signed [CFG_W-1:0] axis_offset;
        logic signed [CFG_W-1:0] base_offset;
        logic [CFG_W-1:0]        inverse_norm;
        logic [DPF_W-1:0]        degrees_per_frame;
    } t_cfg;

    // Beat handed from cell to cell.
    typedef struct packed {
        logic                    valid;
        logic signed [ROT_W-1:0] cx;
        logic signed [ROT_W-1:0] cy;
        t_angle                  za;
        logic signed [OUT_W-1:0] z;
    } t_rot;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } t_point;

    // Clamp to the signed output range.
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] c;
        c = v;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end
        return c[OUT_W-1:0];
    endfunction

endpackage

>>> sv/tilted_axis_pixel_to_point.sv
`timescale 1ns / 1ps

// Channel   | Dir | Handshake          | Beat contents
// pixel     | in  | i_valid / o_stall  | i_pixel_column, i_pixel_row, i_frame_index
// point     | out | o_valid / i_stall  | o_point_x, o_point_y, o_point_z
// config    | in  | i_cfg_wr_en        | i_cfg_index, i_cfg_data
//
// One pixel beat per cycle while o_stall is low; the chain has 9 front stages,
// one register per CORDIC cell (16 at the default) and one output register.
// Pixels beyond the base line are dropped in the third stage and give no point.
// Synchronous active-low reset clears all valid bits and loads the register defaults.
// A consumer stall is absorbed by one skid entry; o_stall is that entry's full flag and
// freezes the whole chain until the point is taken.

module tilted_axis_pixel_to_point import tapp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [COL_W-1:0]     i_pixel_column,
    input  logic [ROW_W-1:0]     i_pixel_row,
    input  logic [FRAME_W-1:0]   i_frame_index,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [OUT_W-1:0] o_point_x,
    output logic signed [OUT_W-1:0] o_point_y,
    output logic signed [OUT_W-1:0] o_point_z,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg   r_cfg;
    logic   w_en;
    t_rot   w_chain [NUM_CELLS+1];
    t_point w_point;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.axis_slope        <= RST_AXIS_SLOPE;
            r_cfg.axis_offset       <= RST_AXIS_OFFSET;
            r_cfg.base_offset       <= RST_BASE_OFFSET;
            r_cfg.inverse_norm      <= RST_INVERSE_NORM;
            r_cfg.degrees_per_frame <= RST_DEG_PER_FRAME;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_AXIS_SLOPE:    r_cfg.axis_slope        <= $signed(i_cfg_data);
                CFG_AXIS_OFFSET:   r_cfg.axis_offset       <= $signed(i_cfg_data);
                CFG_BASE_OFFSET:   r_cfg.base_offset       <= $signed(i_cfg_data);
                CFG_INVERSE_NORM:  r_cfg.inverse_norm      <= i_cfg_data;
                CFG_DEG_PER_FRAME: r_cfg.degrees_per_frame <= i_cfg_data[DPF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Geometry and angle front end.
    tapp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (i_valid),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .i_frame_index  (i_frame_index),
        .i_cfg          (r_cfg),
        .o_rot          (w_chain[0])
    );

    // Row of rotation cells.
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        tapp_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (STAGE_W'(g)),
            .i_rot   (w_chain[g]),
            .o_rot   (w_chain[g+1])
        );
    end

    // Rounding, clamping and output buffering.
    tapp_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rot   (w_chain[NUM_CELLS]),
        .i_stall (i_stall),
        .o_en    (w_en),
        .o_valid (o_valid),
        .o_point (w_point)
    );

    assign o_stall   = !w_en;
    assign o_point_x = w_point.x;
    assign o_point_y = w_point.y;
    assign o_point_z = w_point.z;

endmodule

>>> sv/tapp_front.sv
`timescale 1ns / 1ps

module tapp_front import tapp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [COL_W-1:0]   i_pixel_column,
    input  logic [ROW_W-1:0]   i_pixel_row,
    input  logic [FRAME_W-1:0] i_frame_index,
    input  t_cfg               i_cfg,
    output t_rot               o_rot
);

    logic [FRONT_STAGES-1:0] r_vld;

    // Stage 1: products with the slope and the frame angle.
    logic signed [KX_W-1:0] r1_kx, r1_ky;
    logic [FD_W-1:0]        r1_fd;
    logic [COL_W-1:0]       r1_x;
    logic [ROW_W-1:0]       r1_y;

    // Stage 2: distances to axis and base line.
    logic signed [D_W-1:0]  r2_d0, r2_d1;
    logic [FD_W-1:0]        r2_fd;

    // Stage 3: magnitudes and the angle in degrees.
    logic [MAG_W-1:0]       r3_m0, r3_m1;
    logic [DEG_W-1:0]       r3_deg;

    // Stage 4: normalized radius and height, first residue fold.
    logic [R_W-1:0]         r4_r, r4_zm;
    logic [S1_W-1:0]        r4_s1;
    logic [DEG_W-1:0]       r4_deg;

    // Stage 5: gain pre-scale, clamped height, second residue fold.
    logic [CX_W-1:0]        r5_cx;
    logic signed [OUT_W-1:0] r5_z;
    logic [S2_W-1:0]        r5_s2;
    logic [DEG_W-1:0]       r5_deg;

    // Stage 6: quotient by 45 of the folded residue.
    logic [Q_W-1:0]         r6_q;
    logic [S2_W-1:0]        r6_s2;
    logic [DEG_W-1:0]       r6_deg;
    logic [CX_W-1:0]        r6_cx;
    logic signed [OUT_W-1:0] r6_z;

    // Stage 7: remainder of the degree value modulo 45.
    logic [B_W-1:0]         r7_b;
    logic [DEG_W-1:0]       r7_deg;
    logic [CX_W-1:0]        r7_cx;
    logic signed [OUT_W-1:0] r7_z;

    // Stage 8: binary angle.
    logic [ANG_W-1:0]       r8_ang;
    logic [CX_W-1:0]        r8_cx;
    logic signed [OUT_W-1:0] r8_z;

    // Stage 9: folded start vector.
    logic signed [ROT_W-1:0] r9_cx;
    t_angle                  r9_za;
    logic signed [OUT_W-1:0] r9_z;

    logic signed [D_W-1:0]  n_d0, n_d1, n_abs0, n_abs1;
    logic                   n_keep;
    logic [DEG_W-1:0]       n_deg;
    logic [2*MAG_W-1:0]     n_rprod, n_zprod;
    logic [R_W+GAIN_W-1:0]  n_cxprod;
    logic [QPROD_W-1:0]     n_qprod;
    logic [S2_W-1:0]        n_bfull;
    logic [A_W-1:0]         n_adiff, n_a;
    logic                   n_flip;
    logic signed [ROT_W-1:0] n_cx0;

    // Distances in Q.28 pixels.
    always_comb begin
        n_d0 = D_W'(r1_kx) - $signed({7'b0, r1_y, 28'b0})
             + $signed({{2{i_cfg.axis_offset[CFG_W-1]}}, i_cfg.axis_offset, 12'b0});
        n_d1 = $signed({6'b0, r1_x, 28'b0}) + D_W'(r1_ky)
             + $signed({{2{i_cfg.base_offset[CFG_W-1]}}, i_cfg.base_offset, 12'b0});
    end

    // Drop test, magnitudes and half-turn offset.
    always_comb begin
        n_keep = r2_d1[D_W-1] || (r2_d1 == '0);
        n_abs0 = r2_d0[D_W-1] ? -r2_d0 : r2_d0;
        n_abs1 = r2_d1[D_W-1] ? -r2_d1 : r2_d1;
        n_deg  = {1'b0, r2_fd} + (r2_d0[D_W-1] ? DEG180_Q16 : '0);
    end

    // Multiplies and the residue arithmetic.
    always_comb begin
        n_rprod  = (2 * MAG_W)'(r3_m0) * (2 * MAG_W)'(i_cfg.inverse_norm);
        n_zprod  = (2 * MAG_W)'(r3_m1) * (2 * MAG_W)'(i_cfg.inverse_norm);
        n_cxprod = (R_W + GAIN_W)'(r4_r) * (R_W + GAIN_W)'(INV_GAIN_Q31);
        n_qprod  = QPROD_W'(r5_s2) * QPROD_W'(RECIP45);
        n_bfull  = r6_s2 - S2_W'(r6_q) * S2_W'(MOD_DIV);
        // deg - b is an exact multiple of 45, so the low quotient bits come from
        // a multiply by the inverse of 45 modulo 2^19.
        n_adiff  = r7_deg[A_W-1:0] - A_W'(r7_b);
        n_a      = n_adiff * INV45_MOD;
    end

    // Fold the angle to the right half plane.
    always_comb begin
        n_flip = r8_ang[ANG_W-1] ^ r8_ang[ANG_W-2];
        n_cx0  = ROT_W'(r8_cx);
        if (n_flip) begin
            n_cx0 = -n_cx0;
        end
    end

    // Valid bits; pixels beyond the base line leave the pipe at stage 3.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            r_vld[1] <= r_vld[0];
            r_vld[2] <= r_vld[1] && n_keep;
            r_vld[FRONT_STAGES-1:3] <= r_vld[FRONT_STAGES-2:2];
        end
    end

    // Payload stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_kx  <= KX_W'(i_cfg.axis_slope) * KX_W'($signed({1'b0, i_pixel_column}));
            r1_ky  <= KX_W'(i_cfg.axis_slope) * KX_W'($signed({1'b0, i_pixel_row}));
            r1_fd  <= FD_W'(i_frame_index) * FD_W'(i_cfg.degrees_per_frame);
            r1_x   <= i_pixel_column;
            r1_y   <= i_pixel_row;

            r2_d0  <= n_d0;
            r2_d1  <= n_d1;
            r2_fd  <= r1_fd;

            r3_m0  <= n_abs0[D_W-1:MAG_SHIFT];
            r3_m1  <= n_abs1[D_W-1:MAG_SHIFT];
            r3_deg <= n_deg;

            r4_r   <= n_rprod[2*MAG_W-1:NORM_SHIFT];
            r4_zm  <= n_zprod[2*MAG_W-1:NORM_SHIFT];
            r4_s1  <= S1_W'(r3_deg[CHUNK_W-1:0]) + S1_W'(r3_deg[2*CHUNK_W-1:CHUNK_W])
                    + S1_W'(r3_deg[DEG_W-1:2*CHUNK_W]);
            r4_deg <= r3_deg;

            r5_cx  <= n_cxprod[R_W+GAIN_W-1:GAIN_SHIFT];
            r5_z   <= sat_out(-$signed(SAT_W'(r4_zm)));
            r5_s2  <= S2_W'(r4_s1[CHUNK_W-1:0]) + S2_W'(r4_s1[S1_W-1:CHUNK_W]);
            r5_deg <= r4_deg;

            r6_q   <= n_qprod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
            r6_s2  <= r5_s2;
            r6_deg <= r5_deg;
            r6_cx  <= r5_cx;
            r6_z   <= r5_z;

            r7_b   <= n_bfull[B_W-1:0];
            r7_deg <= r6_deg;
            r7_cx  <= r6_cx;
            r7_z   <= r6_z;

            r8_ang <= {n_a, FRAC_TBL[r7_b]};
            r8_cx  <= r7_cx;
            r8_z   <= r7_z;

            r9_cx  <= n_cx0;
            r9_za  <= $signed({r8_ang[ANG_W-1] ^ n_flip, r8_ang[ANG_W-2:0]});
            r9_z   <= r8_z;
        end
    end

    assign o_rot = '{valid: r_vld[FRONT_STAGES-1], cx: r9_cx, cy: '0, za: r9_za, z: r9_z};

endmodule

>>> sv/tapp_cordic_cell.sv
`timescale 1ns / 1ps

module tapp_cordic_cell import tapp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [STAGE_W-1:0] i_stage,
    input  t_rot               i_rot,
    output t_rot               o_rot
);

    logic                    r_valid;
    logic signed [ROT_W-1:0] r_cx, r_cy;
    t_angle                  r_za;
    logic signed [OUT_W-1:0] r_z;

    logic signed [ROT_W-1:0] n_dx, n_dy, n_cx, n_cy;
    t_angle                  n_za;

    // One micro-rotation toward zero residual angle.
    always_comb begin
        n_dx = i_rot.cy >>> i_stage;
        n_dy = i_rot.cx >>> i_stage;
        if (!i_rot.za[ANG_W-1]) begin
            n_cx = i_rot.cx - n_dx;
            n_cy = i_rot.cy + n_dy;
            n_za = i_rot.za - ATAN_TBL[i_stage];
        end else begin
            n_cx = i_rot.cx + n_dx;
            n_cy = i_rot.cy - n_dy;
            n_za = i_rot.za + ATAN_TBL[i_stage];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_rot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_za <= n_za;
            r_z  <= i_rot.z;
        end
    end

    assign o_rot = '{valid: r_valid, cx: r_cx, cy: r_cy, za: r_za, z: r_z};

endmodule

>>> sv/tapp_out.sv
`timescale 1ns / 1ps

module tapp_out import tapp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_rot   i_rot,
    input  logic   i_stall,
    output logic   o_en,
    output logic   o_valid,
    output t_point o_point
);

    logic   r_ov, r_skid_v;
    t_point r_out, r_skid;

    logic signed [SAT_W-1:0] n_sx, n_sy;
    t_point                  n_pt;
    logic                    n_push, n_pop;

    // Round to Q.10 and clamp.
    always_comb begin
        n_sx   = SAT_W'(i_rot.cx) + RND_HALF;
        n_sy   = SAT_W'(i_rot.cy) + RND_HALF;
        n_pt.x = sat_out(n_sx >>> RND_SHIFT);
        n_pt.y = sat_out(n_sy >>> RND_SHIFT);
        n_pt.z = i_rot.z;
        n_push = o_en && i_rot.valid;
        n_pop  = r_ov && !i_stall;
    end

    // Output register plus one skid entry; the chain halts while the skid is full.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (n_pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (n_push) begin
            if (!r_ov || n_pop) begin
                r_ov <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (n_pop) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (n_pop) begin
                r_out <= r_skid;
            end
        end else if (n_push) begin
            if (!r_ov || n_pop) begin
                r_out <= n_pt;
            end else begin
                r_skid <= n_pt;
            end
        end
    end

    assign o_en    = !r_skid_v;
    assign o_valid = r_ov;
    assign o_point = r_out;

endmodule

>>> sv/tapp_port_chk.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module tapp_port_chk import tapp_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic                    o_stall,
    input logic signed [OUT_W-1:0] o_point_x,
    input logic signed [OUT_W-1:0] o_point_y,
    input logic signed [OUT_W-1:0] o_point_z
);

    // A stalled point beat stays offered.
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "point beat dropped under stall")

    // A stalled point beat keeps its payload.
    `CHK_ASSERT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall |=> $stable(o_point_x) && $stable(o_point_y) && $stable(o_point_z), "point payload changed under stall")

    // Reset leaves an empty pipe that is ready for pixels.
    `CHK_ASSERT_NR(a_rst_empty, i_clk, !i_rst_n |=> !o_valid && !o_stall, "pipe not empty after reset")

    // Kept pixels lie on or below the base line, so height is never positive.
    `CHK_ASSERT(a_z_sign, i_clk, i_rst_n, o_valid |-> (o_point_z[OUT_W-1] || (o_point_z == '0)), "positive height emitted")

endmodule

bind tilted_axis_pixel_to_point tapp_port_chk u_port_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_stall   (o_stall),
    .o_point_x (o_point_x),
    .o_point_y (o_point_y),
    .o_point_z (o_point_z)
);
